>>> src/peak_window_audio_compressor_macros.svh
// Assertion macros for the peak-window audio compressor.
// Depends on nothing; included by the files that assert.
`ifndef PEAK_WINDOW_AUDIO_COMPRESSOR_MACROS_SVH
`define PEAK_WINDOW_AUDIO_COMPRESSOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PWAC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PWAC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/pwac_pkg.sv
// Shared types and constants of the peak-window audio compressor.
// Depends on nothing.
`default_nettype none
package pwac_pkg;
  localparam int LEN_W   = 16;
  localparam int THR_W   = 16;
  localparam int RATIO_W = 7;
  localparam int NUM_W   = 23;  // holds 100 * 65535
  localparam int Q_W     = 17;  // Q16 gain, up to 1.0 inclusive
  localparam int FRAC_W  = 16;
  localparam int IDX_W   = 2;

  typedef enum logic [1:0] {
    PH_NORMAL = 2'd0,
    PH_ATTACK = 2'd1,
    PH_COMP   = 2'd2,
    PH_REL    = 2'd3
  } phase_t;

  localparam logic [IDX_W-1:0] REG_ATTACK_LEN  = 2'd0;
  localparam logic [IDX_W-1:0] REG_RELEASE_LEN = 2'd1;
  localparam logic [IDX_W-1:0] REG_THRESHOLD   = 2'd2;
  localparam logic [IDX_W-1:0] REG_RATIO       = 2'd3;

  typedef struct packed {
    logic [LEN_W-1:0]   attack_len;
    logic [LEN_W-1:0]   release_len;
    logic [THR_W-1:0]   threshold;
    logic [RATIO_W-1:0] ratio_percent;
  } cfg_t;
endpackage
`default_nettype wire

>>> src/pwac_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module pwac_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> src/pwac_queue.sv
// Two-entry queue between the front and the back of the compressor.
// Depends on the assertion macros header only.
`default_nettype none
`include "peak_window_audio_compressor_macros.svh"
module pwac_queue #(
  parameter int WIDTH = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty
);
  logic [WIDTH-1:0] slot_r [2];
  logic             wp_r;
  logic             rp_r;
  logic [1:0]       cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rdata   = slot_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wp_r <= !wp_r;
      end
      if (do_pop) begin
        rp_r <= !rp_r;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= wdata;
    end
  end

  `PWAC_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= 2'd2, "queue count overrun")
  `PWAC_ASSERT_NOW(a_no_push_full, clk, rst_n, push, !full, "push into full queue")
  `PWAC_ASSERT_NEXT(a_pop_drains, clk, rst_n, do_pop && !do_push, cnt_r == $past(cnt_r) - 2'd1, "pop lost")
endmodule
`default_nettype wire

>>> src/pwac_front.sv
// Front of the compressor: window store, peak tracking, phase machine and
// gain fraction set-up. Depends on pwac_pkg and pwac_ram.
`default_nettype none
module pwac_front import pwac_pkg::*; #(
  parameter int WINDOW      = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire cfg_t                   cfg,
  input  wire logic                   push,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  output logic                        full,
  input  wire logic                   q_full,
  output logic                        q_push,
  output logic                        job_neg,
  output logic      [SAMPLE_BITS-1:0] job_mag,
  output logic      [NUM_W-1:0]       job_num,
  output logic      [NUM_W-1:0]       job_den,
  output phase_t                      job_phase
);
  localparam int AW = $clog2(WINDOW);
  localparam int CW = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
  localparam logic [AW-1:0] LAST = AW'(WINDOW - 1);

  typedef enum logic [3:0] {
    F_CLEAR, F_IDLE, F_WRITE, F_SCAN, F_SCAN_END, F_PHASE, F_MUL, F_NUM, F_PUSH
  } fstate_t;

  fstate_t                state_r;
  logic [AW-1:0]          cnt_r;
  logic [AW-1:0]          ws_r;
  logic [AW-1:0]          ps_r;
  logic [SAMPLE_BITS-1:0] pv_r;
  logic                   rd_valid_r;
  logic [AW-1:0]          rd_idx_r;
  phase_t                 ph_r;
  phase_t                 kind_r;
  logic [LEN_W-1:0]       rc_r;
  logic [LEN_W-1:0]       len_r;
  logic [LEN_W-1:0]       prog_r;
  logic [RATIO_W-1:0]     ratio_r;
  logic [NUM_W-1:0]       prodm_r;
  logic [NUM_W-1:0]       prodl_r;
  logic                   neg_r;
  logic [SAMPLE_BITS-1:0] mag_r;
  logic [NUM_W-1:0]       num_r;
  logic [NUM_W-1:0]       den_r;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [SAMPLE_BITS-1:0] ram_wdata;
  logic [SAMPLE_BITS-1:0] ram_rdata;
  logic [SAMPLE_BITS-1:0] in_mag;
  logic [LEN_W-1:0]       eff_att;
  logic [LEN_W-1:0]       eff_rel;
  phase_t                 ph1;
  phase_t                 ph2;
  logic [LEN_W-1:0]       rc1;
  logic [LEN_W-1:0]       rc2;
  logic [LEN_W-1:0]       len1;
  logic [LEN_W-1:0]       prog1;
  logic [RATIO_W-1:0]     ratio_eff;

  pwac_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(WINDOW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt_r),
    .rdata (ram_rdata)
  );

  assign ram_we    = (state_r == F_CLEAR) || (state_r == F_WRITE);
  assign ram_waddr = (state_r == F_CLEAR) ? cnt_r : ws_r;
  assign ram_wdata = (state_r == F_CLEAR) ? '0 : mag_r;
  assign in_mag    = sample[SAMPLE_BITS-1] ? (SAMPLE_BITS'(0) - sample) : sample;
  assign eff_att   = (cfg.attack_len == '0) ? LEN_W'(1) : cfg.attack_len;
  assign eff_rel   = (cfg.release_len == '0) ? LEN_W'(1) : cfg.release_len;
  assign ratio_eff = (cfg.ratio_percent > RATIO_W'(100)) ? RATIO_W'(100) : cfg.ratio_percent;

  assign full      = (state_r != F_IDLE);
  assign q_push    = (state_r == F_PUSH) && !q_full;
  assign job_neg   = neg_r;
  assign job_mag   = mag_r;
  assign job_num   = num_r;
  assign job_den   = den_r;
  assign job_phase = ph_r;

  // phase decision for one nonzero sample
  always_comb begin
    ph1 = ph_r;
    rc1 = rc_r;
    if ((ph_r == PH_NORMAL) && (CW'(pv_r) > CW'(cfg.threshold))) begin
      ph1 = PH_ATTACK;
      rc1 = eff_att;
    end else if ((ph_r == PH_COMP) && (CW'(pv_r) <= CW'(cfg.threshold))) begin
      ph1 = PH_REL;
      rc1 = eff_rel;
    end
    len1  = (ph1 == PH_ATTACK) ? eff_att : ((ph1 == PH_REL) ? eff_rel : LEN_W'(1));
    prog1 = (rc1 > len1) ? '0 : (len1 - rc1);
    rc2   = rc1;
    ph2   = ph1;
    if ((ph1 == PH_ATTACK) || (ph1 == PH_REL)) begin
      if (rc1 != '0) begin
        rc2 = rc1 - LEN_W'(1);
      end
      if (rc2 == '0) begin
        ph2 = (ph1 == PH_ATTACK) ? PH_COMP : PH_NORMAL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= F_CLEAR;
      cnt_r      <= '0;
      ws_r       <= '0;
      ps_r       <= '0;
      pv_r       <= '0;
      rd_valid_r <= 1'b0;
      ph_r       <= PH_NORMAL;
      rc_r       <= '0;
    end else begin
      rd_valid_r <= (state_r == F_SCAN);
      rd_idx_r   <= cnt_r;
      if (rd_valid_r && (ram_rdata > pv_r)) begin
        pv_r <= ram_rdata;
        ps_r <= rd_idx_r;
      end
      unique case (state_r)
        F_CLEAR: begin
          cnt_r <= (cnt_r == LAST) ? '0 : cnt_r + AW'(1);
          if (cnt_r == LAST) begin
            state_r <= F_IDLE;
          end
        end
        F_IDLE: begin
          if (push) begin
            neg_r <= sample[SAMPLE_BITS-1];
            mag_r <= in_mag;
            if (sample == '0) begin
              num_r   <= NUM_W'(1);
              den_r   <= NUM_W'(1);
              state_r <= F_PUSH;
            end else begin
              state_r <= F_WRITE;
            end
          end
        end
        F_WRITE: begin
          ws_r <= (ws_r == LAST) ? '0 : ws_r + AW'(1);
          if (ps_r == ws_r) begin
            pv_r    <= '0;
            ps_r    <= '0;
            cnt_r   <= '0;
            state_r <= F_SCAN;
          end else begin
            if (mag_r > pv_r) begin
              pv_r <= mag_r;
              ps_r <= ws_r;
            end
            state_r <= F_PHASE;
          end
        end
        F_SCAN: begin
          cnt_r <= (cnt_r == LAST) ? '0 : cnt_r + AW'(1);
          if (cnt_r == LAST) begin
            state_r <= F_SCAN_END;
          end
        end
        F_SCAN_END: begin
          state_r <= F_PHASE;
        end
        F_PHASE: begin
          kind_r  <= ph1;
          len_r   <= len1;
          prog_r  <= prog1;
          ratio_r <= ratio_eff;
          ph_r    <= ph2;
          rc_r    <= rc2;
          state_r <= F_MUL;
        end
        F_MUL: begin
          prodm_r <= NUM_W'(RATIO_W'(100) - ratio_r) * NUM_W'(prog_r);
          prodl_r <= NUM_W'(ratio_r) * NUM_W'(len_r);
          den_r   <= NUM_W'(len_r) * NUM_W'(100);
          state_r <= F_NUM;
        end
        F_NUM: begin
          unique case (kind_r)
            PH_NORMAL: begin
              num_r <= NUM_W'(1);
              den_r <= NUM_W'(1);
            end
            PH_COMP: begin
              num_r <= NUM_W'(ratio_r);
              den_r <= NUM_W'(100);
            end
            PH_ATTACK: num_r <= den_r - prodm_r;
            PH_REL:    num_r <= prodl_r + prodm_r;
            default:   num_r <= NUM_W'(1);
          endcase
          state_r <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> src/pwac_back.sv
// Back of the compressor: Q16 gain division, scaling and result register.
// Depends on pwac_pkg.
`default_nettype none
module pwac_back import pwac_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   q_empty,
  output logic                        q_pop,
  input  wire logic                   job_neg,
  input  wire logic [SAMPLE_BITS-1:0] job_mag,
  input  wire logic [NUM_W-1:0]       job_num,
  input  wire logic [NUM_W-1:0]       job_den,
  input  wire phase_t                 job_phase,
  output logic                        empty,
  input  wire logic                   pop,
  output logic      [SAMPLE_BITS-1:0] sample_out,
  output phase_t                      phase
);
  localparam int DW = NUM_W + FRAC_W;
  localparam int PW = SAMPLE_BITS + Q_W;
  localparam logic [5:0] LAST_STEP = 6'(DW - 1);

  typedef enum logic [1:0] {B_IDLE, B_DIV, B_MUL, B_DONE} bstate_t;

  bstate_t                state_r;
  logic [5:0]             step_r;
  logic [DW-1:0]          div_r;
  logic [NUM_W-1:0]       rem_r;
  logic [NUM_W-1:0]       den_r;
  logic                   neg_r;
  logic [SAMPLE_BITS-1:0] mag_r;
  phase_t                 ph_r;
  logic [PW-1:0]          prod_r;
  logic                   ov_r;
  logic [SAMPLE_BITS-1:0] out_r;
  phase_t                 oph_r;
  logic [NUM_W:0]         rem_sh;
  logic                   qbit;
  logic [SAMPLE_BITS-1:0] omag;

  assign q_pop      = (state_r == B_IDLE) && !q_empty;
  assign rem_sh     = {rem_r, div_r[DW-1]};
  assign qbit       = (rem_sh >= {1'b0, den_r});
  assign omag       = prod_r[FRAC_W +: SAMPLE_BITS];
  assign empty      = !ov_r;
  assign sample_out = out_r;
  assign phase      = oph_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      ov_r    <= 1'b0;
    end else begin
      if (pop && ov_r) begin
        ov_r <= 1'b0;
      end
      unique case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            neg_r   <= job_neg;
            mag_r   <= job_mag;
            ph_r    <= job_phase;
            den_r   <= job_den;
            div_r   <= {job_num, FRAC_W'(0)};
            rem_r   <= '0;
            step_r  <= '0;
            state_r <= B_DIV;
          end
        end
        B_DIV: begin
          rem_r  <= qbit ? NUM_W'(rem_sh - {1'b0, den_r}) : rem_sh[NUM_W-1:0];
          div_r  <= {div_r[DW-2:0], qbit};
          step_r <= step_r + 6'd1;
          if (step_r == LAST_STEP) begin
            state_r <= B_MUL;
          end
        end
        B_MUL: begin
          prod_r  <= mag_r * div_r[Q_W-1:0];
          state_r <= B_DONE;
        end
        B_DONE: begin
          if (!ov_r || pop) begin
            out_r   <= neg_r ? (SAMPLE_BITS'(0) - omag) : omag;
            oph_r   <= ph_r;
            ov_r    <= 1'b1;
            state_r <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> src/peak_window_audio_compressor.sv
// Top level of the peak-window audio compressor: configuration registers,
// front, queue and back. Depends on pwac_pkg, pwac_front, pwac_queue, pwac_back.
//
// Signed samples enter through push/full and leave, scaled and tagged with
// the compressor phase, through empty/pop, one result per sample and in
// order. A zero sample passes through as zero and touches no state. After
// reset the window store is swept to zero, during which full stays high;
// configuration writes are taken at any time (cfg_ready is always high).
// A zero sample goes straight to the queue; any other is written to the
// window and passes the phase, multiply and numerator steps, after a
// rescan of the whole window through the single read port of the window
// RAM when the slot holding the current peak is overwritten. The back
// divides the gain fraction with a restoring divider that yields one bit
// per cycle over 39 steps, then multiplies and loads the result register;
// the back sets the sustained rate when no rescan occurs. A two-entry
// queue lets the front work on the next sample while the back divides, and
// the back starts the next division while a result waits to be popped.
`default_nettype none
module peak_window_audio_compressor import pwac_pkg::*; #(
  parameter int WINDOW      = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   push,
  input  wire logic [SAMPLE_BITS-1:0] in_sample_in,
  output logic                        full,
  output logic                        empty,
  input  wire logic                   pop,
  output logic      [SAMPLE_BITS-1:0] out_sample_out,
  output logic      [1:0]             out_phase,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [IDX_W-1:0]       cfg_index,
  input  wire logic [LEN_W-1:0]       cfg_wdata
);
  localparam int JW = 1 + SAMPLE_BITS + 2 * NUM_W + 2;

  cfg_t                   cfg_r;
  logic                   q_full;
  logic                   q_empty;
  logic                   q_push;
  logic                   q_pop;
  logic [JW-1:0]          q_wdata;
  logic [JW-1:0]          q_rdata;
  logic                   f_neg;
  logic [SAMPLE_BITS-1:0] f_mag;
  logic [NUM_W-1:0]       f_num;
  logic [NUM_W-1:0]       f_den;
  phase_t                 f_phase;
  logic                   b_neg;
  logic [SAMPLE_BITS-1:0] b_mag;
  logic [NUM_W-1:0]       b_num;
  logic [NUM_W-1:0]       b_den;
  phase_t                 b_phase;
  phase_t                 o_phase;

  assign cfg_ready = 1'b1;

  // Register file: store each beat truncated to the register's width.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.attack_len    <= LEN_W'(48);
      cfg_r.release_len   <= LEN_W'(48);
      cfg_r.threshold     <= THR_W'(64);
      cfg_r.ratio_percent <= RATIO_W'(30);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ATTACK_LEN:  cfg_r.attack_len    <= cfg_wdata;
        REG_RELEASE_LEN: cfg_r.release_len   <= cfg_wdata;
        REG_THRESHOLD:   cfg_r.threshold     <= cfg_wdata[THR_W-1:0];
        REG_RATIO:       cfg_r.ratio_percent <= cfg_wdata[RATIO_W-1:0];
        default:         cfg_r.attack_len    <= cfg_r.attack_len;
      endcase
    end
  end

  pwac_front #(.WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .push      (push),
    .sample    (in_sample_in),
    .full      (full),
    .q_full    (q_full),
    .q_push    (q_push),
    .job_neg   (f_neg),
    .job_mag   (f_mag),
    .job_num   (f_num),
    .job_den   (f_den),
    .job_phase (f_phase)
  );

  // Pack the job beat for the queue, unpack it on the far side.
  assign q_wdata = {f_neg, f_mag, f_num, f_den, f_phase};
  assign {b_neg, b_mag, b_num, b_den} = q_rdata[JW-1:2];
  assign b_phase = phase_t'(q_rdata[1:0]);

  pwac_queue #(.WIDTH(JW)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  pwac_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .job_neg    (b_neg),
    .job_mag    (b_mag),
    .job_num    (b_num),
    .job_den    (b_den),
    .job_phase  (b_phase),
    .empty      (empty),
    .pop        (pop),
    .sample_out (out_sample_out),
    .phase      (o_phase)
  );

  assign out_phase = o_phase;
endmodule
`default_nettype wire
